// ===== src/q4dp_pkg.sv =====
// ----------------------------------------------------------------------------
// q4dp_pkg
// Types and constants shared by the 4-bit quantized dot-product block.
// ----------------------------------------------------------------------------
package q4dp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned NibW   = 4;
  localparam int unsigned ActW   = 16;
  localparam int unsigned ScaleW = 16;
  localparam int unsigned ProdW  = NibW + ActW;      // nibble weight times activation
  localparam int unsigned PairW  = ProdW + 1;        // sum of the two products
  localparam int unsigned TermW  = 36;               // |term| <= 2^34
  localparam int unsigned AccW   = 56;

  // Nibble minus 8, as two's complement: flip the top bit.
  localparam logic [NibW-1:0] NibbleBias = 4'h8;

  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

  // One scaled term on its way from the front to the accumulator.
  typedef struct packed {
    logic signed [TermW-1:0] term;
    logic                    last;
  } term_item_t;

  // One finished row.
  typedef struct packed {
    logic signed [AccW-1:0] row_sum;
    logic                   saturated;
  } row_result_t;

endpackage

// ===== src/q4dp_fifo.sv =====
// ----------------------------------------------------------------------------
// q4dp_fifo
// Small flip-flop queue with push/full and pop/empty on its two sides.
// ----------------------------------------------------------------------------
module q4dp_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == DepthCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthCnt)
    else $error("fifo count beyond depth");
`endif

endmodule

// ===== src/q4dp_front.sv =====
// ----------------------------------------------------------------------------
// q4dp_front
// Takes weight-byte beats, unpacks the nibbles and forms the scaled term
// in two multiply stages.
// ----------------------------------------------------------------------------
module q4dp_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  logic [q4dp_pkg::ByteW-1:0]         weight_byte_i,
  input  logic signed [q4dp_pkg::ActW-1:0]   act_even_i,
  input  logic signed [q4dp_pkg::ActW-1:0]   act_odd_i,
  input  logic signed [q4dp_pkg::ScaleW-1:0] group_scale_i,
  input  logic                               last_of_row_i,
  output logic                               tq_push_o,
  output q4dp_pkg::term_item_t               tq_item_o,
  input  logic                               tq_full_i
);
  import q4dp_pkg::*;

  logic                     v1_q, v2_q;
  logic signed [PairW-1:0]  pair_q;
  logic signed [ScaleW-1:0] scale_q;
  logic                     last1_q;
  term_item_t               item_q;

  logic signed [NibW-1:0]   q0, q1;
  logic signed [ProdW-1:0]  p0, p1;
  logic signed [PairW-1:0]  pair_d;
  logic signed [TermW-1:0]  term_d;
  logic                     adv, take;

  // Stage 2 moves on when it is empty or its beat leaves for the queue.
  assign adv  = !v2_q || !tq_full_i;
  assign full = v1_q && !adv;
  assign take = push && !full;

  assign q0     = signed'(weight_byte_i[NibW-1:0] ^ NibbleBias);
  assign q1     = signed'(weight_byte_i[ByteW-1:NibW] ^ NibbleBias);
  assign p0     = q0 * act_even_i;
  assign p1     = q1 * act_odd_i;
  assign pair_d = PairW'(p0) + PairW'(p1);
  assign term_d = pair_q * scale_q;

  assign tq_push_o = v2_q;
  assign tq_item_o = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv) begin
        v2_q <= v1_q;
        v1_q <= take;
      end else if (!v1_q) begin
        v1_q <= take;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      pair_q  <= pair_d;
      scale_q <= group_scale_i;
      last1_q <= last_of_row_i;
    end
    if (adv && v1_q) begin
      item_q.term <= term_d;
      item_q.last <= last1_q;
    end
  end

`ifndef SYNTHESIS
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && tq_full_i) |=> (v2_q && $stable(item_q)))
    else $error("stalled term changed");
`endif

endmodule

// ===== src/q4dp_back.sv =====
// ----------------------------------------------------------------------------
// q4dp_back
// Saturating row accumulator: drains terms, closes the row on the last beat.
// ----------------------------------------------------------------------------
module q4dp_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  q4dp_pkg::term_item_t   tq_item_i,
  input  logic                   tq_empty_i,
  output logic                   tq_pop_o,
  output logic                   rq_push_o,
  output q4dp_pkg::row_result_t  rq_item_o,
  input  logic                   rq_full_i
);
  import q4dp_pkg::*;

  logic signed [AccW-1:0] acc_q, acc_d, sum_sat;
  logic                   clip_q, clip_d;
  logic signed [AccW:0]   sum_w;
  logic                   ovf;

  // A closing beat waits for room in the result queue.
  assign tq_pop_o  = !tq_empty_i && (!tq_item_i.last || !rq_full_i);
  assign rq_push_o = tq_pop_o && tq_item_i.last;

  assign sum_w   = {acc_q[AccW-1], acc_q} + (AccW+1)'(tq_item_i.term);
  assign ovf     = sum_w[AccW] != sum_w[AccW-1];
  assign sum_sat = ovf ? (sum_w[AccW] ? AccMin : AccMax) : sum_w[AccW-1:0];

  assign rq_item_o.row_sum   = sum_sat;
  assign rq_item_o.saturated = clip_q || ovf;

  always_comb begin
    acc_d  = acc_q;
    clip_d = clip_q;
    if (tq_pop_o) begin
      if (tq_item_i.last) begin
        acc_d  = '0;
        clip_d = 1'b0;
      end else begin
        acc_d  = sum_sat;
        clip_d = clip_q || ovf;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      clip_q <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      clip_q <= clip_d;
    end
  end

`ifndef SYNTHESIS
  a_clear_after_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rq_push_o |=> (acc_q == '0 && !clip_q))
    else $error("row state not cleared");
  a_clip_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (clip_q && !rq_push_o) |=> clip_q)
    else $error("clip flag lost inside a row");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rq_push_o |-> !rq_full_i)
    else $error("row result pushed into full queue");
`endif

endmodule

// ===== src/q4_block_dot_product.sv =====
// ----------------------------------------------------------------------------
// q4_block_dot_product
// One row of a 4-bit quantized matrix-vector product, Q33.23 saturating sum.
// ----------------------------------------------------------------------------
//   side    | handshake         | beat payload
//   --------+-------------------+---------------------------------------------
//   input   | push / full       | weight_byte, act_even, act_odd, group_scale,
//           |                   | last_of_row
//   result  | empty / pop       | row_sum, saturated
//
// One beat per cycle unless stalled; the accumulator adds one beat a cycle.
// A row result goes through the pair and term registers and both queues.
// Reset clears the accumulator, the clip flag and both queues.
// A full result queue stalls the accumulator at a closing beat, which fills
// the term queue and then stalls the multiply stages and raises full.
// ----------------------------------------------------------------------------
module q4_block_dot_product #(
  parameter int unsigned TermQDepth = 4,
  parameter int unsigned ResQDepth  = 2
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  logic [q4dp_pkg::ByteW-1:0]         weight_byte_i,
  input  logic signed [q4dp_pkg::ActW-1:0]   act_even_i,
  input  logic signed [q4dp_pkg::ActW-1:0]   act_odd_i,
  input  logic signed [q4dp_pkg::ScaleW-1:0] group_scale_i,
  input  logic                               last_of_row_i,
  output logic                               empty,
  input  logic                               pop,
  output logic signed [q4dp_pkg::AccW-1:0]   row_sum_o,
  output logic                               saturated_o
);
  import q4dp_pkg::*;

  localparam int unsigned TermItemW = $bits(term_item_t);
  localparam int unsigned ResItemW  = $bits(row_result_t);

  logic        tq_push, tq_full, tq_pop, tq_empty;
  term_item_t  tq_wr, tq_rd;
  logic        rq_push, rq_full;
  row_result_t rq_wr, rq_rd;

  q4dp_front u_front (
    .clk_i,
    .rst_ni,
    .push,
    .full,
    .weight_byte_i,
    .act_even_i,
    .act_odd_i,
    .group_scale_i,
    .last_of_row_i,
    .tq_push_o (tq_push),
    .tq_item_o (tq_wr),
    .tq_full_i (tq_full)
  );

  q4dp_fifo #(
    .Width (TermItemW),
    .Depth (TermQDepth)
  ) u_term_q (
    .clk_i,
    .rst_ni,
    .push_i  (tq_push),
    .wdata_i (tq_wr),
    .full_o  (tq_full),
    .pop_i   (tq_pop),
    .rdata_o (tq_rd),
    .empty_o (tq_empty)
  );

  q4dp_back u_back (
    .clk_i,
    .rst_ni,
    .tq_item_i  (tq_rd),
    .tq_empty_i (tq_empty),
    .tq_pop_o   (tq_pop),
    .rq_push_o  (rq_push),
    .rq_item_o  (rq_wr),
    .rq_full_i  (rq_full)
  );

  q4dp_fifo #(
    .Width (ResItemW),
    .Depth (ResQDepth)
  ) u_res_q (
    .clk_i,
    .rst_ni,
    .push_i  (rq_push),
    .wdata_i (rq_wr),
    .full_o  (rq_full),
    .pop_i   (pop),
    .rdata_o (rq_rd),
    .empty_o (empty)
  );

  assign row_sum_o   = rq_rd.row_sum;
  assign saturated_o = rq_rd.saturated;

endmodule

// ===== tb/q4dp_row_checker.sv =====
// ----------------------------------------------------------------------------
// q4dp_row_checker
// Watches both queue sides of the Q4 dot-product block and checks row sums.
// Every beat taken on the input side goes through a local copy of the
// saturating Q33.23 accumulator. A beat marked last queues the expected row
// sum and clip flag. Every row popped on the result side is compared field
// by field with the oldest queued row.
// ----------------------------------------------------------------------------
module q4dp_row_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push_i,
  input  logic                               full_i,
  input  logic [q4dp_pkg::ByteW-1:0]         weight_byte_i,
  input  logic signed [q4dp_pkg::ActW-1:0]   act_even_i,
  input  logic signed [q4dp_pkg::ActW-1:0]   act_odd_i,
  input  logic signed [q4dp_pkg::ScaleW-1:0] group_scale_i,
  input  logic                               last_of_row_i,
  input  logic                               empty_i,
  input  logic                               pop_i,
  input  logic signed [q4dp_pkg::AccW-1:0]   row_sum_i,
  input  logic                               saturated_i,
  output int                                 mismatches_o,
  output int                                 rows_pending_o,
  output int                                 rows_checked_o,
  output int                                 beats_taken_o,
  output int                                 rows_clipped_o
);
  import q4dp_pkg::*;

  localparam longint SumTop    = AccMax;
  localparam longint SumBottom = AccMin;

  longint      row_acc;
  logic        row_clip;
  row_result_t expected_rows[$];

  // (q_even * a_even + q_odd * a_odd) * scale, exact; nibbles carry a bias of 8
  function automatic longint scaled_pair(input logic [ByteW-1:0]         wb,
                                         input logic signed [ActW-1:0]   ae,
                                         input logic signed [ActW-1:0]   ao,
                                         input logic signed [ScaleW-1:0] sc);
    longint w_even;
    longint w_odd;
    longint a_even;
    longint a_odd;
    longint s;
    w_even = longint'(wb[NibW-1:0]) - longint'(NibbleBias);
    w_odd  = longint'(wb[ByteW-1:NibW]) - longint'(NibbleBias);
    a_even = ae;
    a_odd  = ao;
    s      = sc;
    return (w_even * a_even + w_odd * a_odd) * s;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("checker: row %0d: %s", rows_checked_o, msg);
    mismatches_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    row_result_t head;
    longint      sum;
    if (!rst_ni) begin
      row_acc  = 0;
      row_clip = 1'b0;
      expected_rows.delete();
      mismatches_o   = 0;
      rows_pending_o = 0;
      rows_checked_o = 0;
      beats_taken_o  = 0;
      rows_clipped_o = 0;
    end else begin
      // a row leaving now was queued at an earlier beat
      if (pop_i && !empty_i) begin
        if (expected_rows.size() == 0) begin
          report_mismatch($sformatf("row sum %0d arrived with no row pending", row_sum_i));
        end else begin
          head = expected_rows.pop_front();
          if (row_sum_i !== head.row_sum)
            report_mismatch($sformatf("row_sum got %0d, wanted %0d",
                                      row_sum_i, head.row_sum));
          if (saturated_i !== head.saturated)
            report_mismatch($sformatf("saturated got %0b, wanted %0b",
                                      saturated_i, head.saturated));
          rows_checked_o++;
        end
      end
      if (push_i && !full_i) begin
        beats_taken_o++;
        sum = row_acc + scaled_pair(weight_byte_i, act_even_i, act_odd_i, group_scale_i);
        if (sum > SumTop) begin
          sum      = SumTop;
          row_clip = 1'b1;
        end else if (sum < SumBottom) begin
          sum      = SumBottom;
          row_clip = 1'b1;
        end
        row_acc = sum;
        if (last_of_row_i) begin
          head.row_sum   = row_acc[AccW-1:0];
          head.saturated = row_clip;
          expected_rows.push_back(head);
          if (row_clip) rows_clipped_o++;
          row_acc  = 0;
          row_clip = 1'b0;
        end
      end
      rows_pending_o = expected_rows.size();
    end
  end

endmodule

// ===== tb/q4_block_dot_product_test.sv =====
// ----------------------------------------------------------------------------
// q4_block_dot_product_test
// Stimulus and verdict for the Q4 quantized dot-product block.
// Directed rows hit the field extremes and a group-scale change; a receiver
// hold-off backs the block up until full rises; then random rows run with
// random idling on both sides.
// Checking lives in q4dp_row_checker.
// ----------------------------------------------------------------------------
module q4_block_dot_product_test;
  import q4dp_pkg::*;

  typedef enum int {RxSteady, RxJittery} rx_mode_e;

  localparam int IdleLimit   = 2000;
  localparam int HoldCycles  = 300;
  localparam int RandomBeats = 750;
  localparam int GroupBytes  = 16;            // 32 weights share one scale

  localparam logic signed [ActW-1:0]   ActLow    = 16'sh8000;
  localparam logic signed [ActW-1:0]   ActHigh   = 16'sh7FFF;
  localparam logic signed [ScaleW-1:0] ScaleLow  = 16'sh8000;
  localparam logic signed [ScaleW-1:0] ScaleHigh = 16'sh7FFF;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     push          = 1'b0;
  logic                     pop           = 1'b0;
  logic [ByteW-1:0]         weight_byte   = '0;
  logic signed [ActW-1:0]   act_even      = '0;
  logic signed [ActW-1:0]   act_odd       = '0;
  logic signed [ScaleW-1:0] group_scale   = '0;
  logic                     last_of_row   = 1'b0;
  logic                     full;
  logic                     empty;
  logic signed [AccW-1:0]   row_sum;
  logic                     saturated;

  int mismatches;
  int rows_pending;
  int rows_checked;
  int beats_taken;
  int rows_clipped;
  int idle_cycles = 0;

  rx_mode_e rx_mode  = RxSteady;
  bit       hold_req = 1'b0;

  always #4 clk_i = ~clk_i;

  q4_block_dot_product uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .weight_byte_i (weight_byte),
    .act_even_i    (act_even),
    .act_odd_i     (act_odd),
    .group_scale_i (group_scale),
    .last_of_row_i (last_of_row),
    .empty         (empty),
    .pop           (pop),
    .row_sum_o     (row_sum),
    .saturated_o   (saturated)
  );

  q4dp_row_checker rows_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_i         (full),
    .weight_byte_i  (weight_byte),
    .act_even_i     (act_even),
    .act_odd_i      (act_odd),
    .group_scale_i  (group_scale),
    .last_of_row_i  (last_of_row),
    .empty_i        (empty),
    .pop_i          (pop),
    .row_sum_i      (row_sum),
    .saturated_i    (saturated),
    .mismatches_o   (mismatches),
    .rows_pending_o (rows_pending),
    .rows_checked_o (rows_checked),
    .beats_taken_o  (beats_taken),
    .rows_clipped_o (rows_clipped)
  );

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 15);
  endfunction

  function automatic logic signed [ActW-1:0] pick_value();
    case ($urandom_range(19, 0))
      0:       return ActLow;
      1:       return ActHigh;
      2:       return '0;
      default: return 16'($urandom());
    endcase
  endfunction

  // receiver: random stalls in stretches, calm stretches, or one long hold-off
  initial begin : receiver
    int stall_left;
    int stretch_left;
    bit calm;
    stall_left   = 0;
    stretch_left = 0;
    calm         = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stretch_left == 0) begin
        stretch_left = $urandom_range(200, 50);
        calm         = ($urandom_range(3, 0) == 0);
      end else begin
        stretch_left--;
      end
      if (hold_req) begin
        stall_left = HoldCycles;
        hold_req   = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if (rx_mode == RxJittery && !calm) begin
        stall_left = pick_gap();
      end
      pop <= (stall_left == 0);
    end
  end

  // entered and left at a falling edge
  task automatic send_beat(input logic [ByteW-1:0]         wb,
                           input logic signed [ActW-1:0]   ae,
                           input logic signed [ActW-1:0]   ao,
                           input logic signed [ScaleW-1:0] sc,
                           input logic                     last,
                           input int                       gap);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push        <= 1'b1;
    weight_byte <= wb;
    act_even    <= ae;
    act_odd     <= ao;
    group_scale <= sc;
    last_of_row <= last;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
  endtask

  task automatic drain_rows();
    push <= 1'b0;
    while (rows_pending != 0) @(negedge clk_i);
  endtask

  // only called with push low, so the rising edge takes no beat
  task automatic set_receiver(input rx_mode_e mode, input bit hold);
    @(posedge clk_i);
    rx_mode  = mode;
    hold_req = hold;
    @(negedge clk_i);
  endtask

  task automatic directed_rows();
    int i;
    send_beat(8'h00, ActLow, ActLow, ScaleLow, 1'b1, pick_gap());
    send_beat(8'hFF, ActHigh, ActHigh, ScaleHigh, 1'b1, pick_gap());
    send_beat(8'h88, ActHigh, ActLow, ScaleHigh, 1'b1, pick_gap());
    send_beat(8'h0F, ActLow, ActHigh, ScaleHigh, 1'b0, pick_gap());
    send_beat(8'hF0, ActHigh, ActLow, ScaleLow, 1'b0, pick_gap());
    send_beat(8'h5A, 16'sh0100, 16'shFF00, ScaleLow, 1'b1, pick_gap());
    // row crossing a group boundary: scale changes after 16 bytes
    for (i = 0; i < 18; i++)
      send_beat(8'(i * 29 + 3), 16'(i * 3001 - 27000), 16'(20000 - i * 2500),
                (i < GroupBytes) ? 16'sh4000 : 16'shE000, i == 17, pick_gap());
  endtask

  task automatic random_rows(input int beats);
    int                       sent;
    int                       row_len;
    int                       i;
    int                       r;
    bit                       burst;
    logic signed [ScaleW-1:0] sc;
    sent = 0;
    sc   = '0;
    while (sent < beats) begin
      r = $urandom_range(99, 0);
      if (r < 60)      row_len = $urandom_range(4, 1);
      else if (r < 92) row_len = $urandom_range(24, 5);
      else             row_len = $urandom_range(80, 25);
      burst = ($urandom_range(3, 0) == 0);
      for (i = 0; i < row_len; i++) begin
        if (i % GroupBytes == 0) sc = pick_value();
        send_beat(8'($urandom()), pick_value(), pick_value(), sc, i == row_len - 1,
                  burst ? 0 : pick_gap());
      end
      sent += row_len;
    end
  endtask

  initial begin : stimulus
    int i;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    set_receiver(RxJittery, 1'b0);
    directed_rows();
    drain_rows();

    // hold the result side while single-beat rows keep coming: full must rise
    set_receiver(RxSteady, 1'b1);
    for (i = 0; i < 24; i++)
      send_beat(8'($urandom()), pick_value(), pick_value(), pick_value(), 1'b1, 0);
    drain_rows();

    set_receiver(RxJittery, 1'b0);
    random_rows(RandomBeats);
    drain_rows();
    repeat (8) @(negedge clk_i);

    $display("summary: %0d beats taken, %0d row sums compared, %0d clipped rows, %0d mismatches",
             beats_taken, rows_checked, rows_clipped, mismatches);
    $display("summary: field extremes, group scale change, %0d-cycle hold-off",
             HoldCycles);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("watchdog: no beat taken for %0d cycles", IdleLimit);
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
